/* sv/dgs_pkg.sv */
// Package for the detent goal block: action codes, register indexes and the
// remainder step of the pipelined divider. Depends on nothing.
package dgs_pkg;

	// Default angle width in bits (signed fixed point, 1/256 degree by default).
	localparam int ANGLE_WIDTH_DEF = 32;

	// Fixed widths of the spacing register and the register index.
	localparam int SPACING_W   = 17;
	localparam int CFG_INDEX_W = 3;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Action reported with every goal.
	typedef enum logic [1:0] {
		ACT_END   = 2'd0,
		ACT_START = 2'd1,
		ACT_SNAP  = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [SPACING_W-1:0]   spacing_t;

	// Configuration register indexes.
	localparam cfg_index_t REG_START_LIMIT_ON = 3'd0;
	localparam cfg_index_t REG_END_LIMIT_ON   = 3'd1;
	localparam cfg_index_t REG_DETENTS_ON     = 3'd2;
	localparam cfg_index_t REG_DETENT_SPACING = 3'd3;
	localparam cfg_index_t REG_START_ANGLE    = 3'd4;
	localparam cfg_index_t REG_END_ANGLE      = 3'd5;

	// The write data must hold both an angle and the spacing.
	function automatic int cfg_data_width(int angle_width);
		return (angle_width > SPACING_W) ? angle_width : SPACING_W;
	endfunction

	// One restoring step: shift in the next dividend bit and subtract the
	// spacing when it fits. The partial remainder stays below the spacing.
	function automatic spacing_t rem_step(spacing_t rem, logic din, spacing_t sp);
		logic [SPACING_W:0] t;
		t = {rem, din};
		if (t >= {1'b0, sp}) begin
			t = t - {1'b0, sp};
		end
		return t[SPACING_W-1:0];
	endfunction

endpackage

/* sv/dgs_if.sv */
// Channel interfaces of the detent goal block: measured angle in, goal out,
// and the configuration write channel. Depends on dgs_pkg.

// Measured angle stream.
interface dgs_angle_if #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] current_angle;

	modport source(output valid, output current_angle, input ready);
	modport sink(input valid, input current_angle, output ready);
endinterface

// Goal stream.
interface dgs_goal_if #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] goal_angle;
	dgs_pkg::action_t              action;

	modport source(output valid, output goal_angle, output action, input ready);
	modport sink(input valid, input goal_angle, input action, output ready);
endinterface

// Configuration write channel.
interface dgs_cfg_if #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
);
	localparam int DATA_W = dgs_pkg::cfg_data_width(ANGLE_WIDTH);

	logic                  valid;
	logic                  ready;
	dgs_pkg::cfg_index_t   index;
	logic [DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/dgs_front.sv */
// Front of the detent goal block: configuration registers, input capture and
// classification of each angle. Depends on dgs_pkg and dgs_if.
module dgs_front #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dgs_angle_if.sink                     angle,
	dgs_cfg_if.sink                       cfg,
	output logic                          wr_valid,
	input  logic                          wr_ready,
	output logic [ANGLE_WIDTH+2:0]        wr_data,
	output dgs_pkg::spacing_t             spacing,
	output logic signed [ANGLE_WIDTH-1:0] start_angle,
	output logic signed [ANGLE_WIDTH-1:0] end_angle
);
	import dgs_pkg::*;

	localparam int DW = ANGLE_WIDTH + 1;

	logic                          start_limit_on_q;
	logic                          end_limit_on_q;
	logic                          detents_on_q;
	spacing_t                      detent_spacing_q;
	logic signed [ANGLE_WIDTH-1:0] start_angle_q;
	logic signed [ANGLE_WIDTH-1:0] end_angle_q;

	logic                          valid_s1;
	logic signed [ANGLE_WIDTH-1:0] cur_s1;

	logic                          end_hit;
	logic                          start_hit;
	action_t                       act;
	logic [DW-1:0]                 diff;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_limit_on_q <= 1'b0;
			end_limit_on_q   <= 1'b0;
			detents_on_q     <= 1'b0;
			detent_spacing_q <= '0;
			start_angle_q    <= '0;
			end_angle_q      <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_LIMIT_ON: start_limit_on_q <= cfg.data[0];
				REG_END_LIMIT_ON:   end_limit_on_q   <= cfg.data[0];
				REG_DETENTS_ON:     detents_on_q     <= cfg.data[0];
				REG_DETENT_SPACING: detent_spacing_q <= cfg.data[SPACING_W-1:0];
				REG_START_ANGLE:    start_angle_q    <= cfg.data[ANGLE_WIDTH-1:0];
				REG_END_ANGLE:      end_angle_q      <= cfg.data[ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign spacing     = detent_spacing_q;
	assign start_angle = start_angle_q;
	assign end_angle   = end_angle_q;

	// The capture stage frees up whenever its transaction moves into the queue.
	assign wr_valid    = valid_s1;
	assign angle.ready = !valid_s1 || wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (angle.valid && angle.ready) begin
			valid_s1 <= 1'b1;
		end else if (wr_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (angle.valid && angle.ready) begin
			cur_s1 <= angle.current_angle;
		end
	end

	// Classify in priority order: end stop, start stop, detent snap, stop.
	assign end_hit   = end_limit_on_q && (cur_s1 > end_angle_q);
	assign start_hit = start_limit_on_q && (cur_s1 < start_angle_q);
	assign diff      = {cur_s1[ANGLE_WIDTH-1], cur_s1}
	                 - {start_angle_q[ANGLE_WIDTH-1], start_angle_q};

	always_comb begin
		if (end_hit) begin
			act = ACT_END;
		end else if (start_hit) begin
			act = ACT_START;
		end else if (detents_on_q && (detent_spacing_q != '0)) begin
			act = ACT_SNAP;
		end else begin
			act = ACT_STOP;
		end
	end

	assign wr_data = {act, diff};

endmodule

/* sv/dgs_queue.sv */
// Short queue that decouples the front from the back of the detent goal block.
// Depends on dgs_pkg for its default depth.
module dgs_queue #(
	parameter int DATA_W = 35,
	parameter int DEPTH  = dgs_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output logic [DATA_W-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [0:DEPTH-1];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* sv/dgs_back.sv */
// Back of the detent goal block: pipelined remainder divider, rounding and
// saturation, and the output register. Depends on dgs_pkg and dgs_if.
module dgs_back #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_valid,
	output logic                          rd_ready,
	input  logic [ANGLE_WIDTH+2:0]        rd_data,
	input  dgs_pkg::spacing_t             spacing,
	input  logic signed [ANGLE_WIDTH-1:0] start_angle,
	input  logic signed [ANGLE_WIDTH-1:0] end_angle,
	dgs_goal_if.source                    goal
);
	import dgs_pkg::*;

	// Offset magnitude, rounded magnitude and goal sum widths.
	localparam int DW = ANGLE_WIDTH + 1;
	localparam int MW = ANGLE_WIDTH + 2;
	localparam int SW = ANGLE_WIDTH + 3;

	logic             advance;
	action_t          head_act;
	logic [DW-1:0]    head_diff;
	logic [DW-1:0]    head_mag;

	// Index k of each array is divider stage s2+k; index 0 is loaded from the queue.
	logic             div_valid_s2 [0:DW];
	action_t          div_act_s2   [0:DW];
	logic             div_neg_s2   [0:DW];
	logic [DW-1:0]    div_mag_s2   [0:DW];
	spacing_t         div_rem_s2   [0:DW];

	logic             rnd_valid_s3;
	action_t          rnd_act_s3;
	logic             rnd_neg_s3;
	logic [MW-1:0]    rnd_mag_s3;

	logic             out_valid_q;
	logic signed [ANGLE_WIDTH-1:0] goal_q;
	action_t          action_q;

	spacing_t         fin_rem;
	logic             round_up;
	logic [MW-1:0]    rnd_mag_next;
	logic [SW-1:0]    st_ext;
	logic [SW-1:0]    mag_ext;
	logic [SW-1:0]    goal_sum;
	logic [3:0]       sum_top;
	logic [ANGLE_WIDTH-1:0] snap_goal;
	logic [ANGLE_WIDTH-1:0] goal_next;

	// The whole back pipeline moves together whenever the output register frees.
	assign advance  = !out_valid_q || goal.ready;
	assign rd_ready = advance;

	// Queue entry: action code over the signed offset from the start angle.
	assign head_act  = action_t'(rd_data[SW-1:DW]);
	assign head_diff = rd_data[DW-1:0];
	assign head_mag  = head_diff[DW-1] ? (~head_diff + DW'(1)) : head_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DW; k++) begin
				div_valid_s2[k] <= 1'b0;
			end
			rnd_valid_s3 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			div_valid_s2[0] <= rd_valid;
			for (int k = 0; k < DW; k++) begin
				div_valid_s2[k+1] <= div_valid_s2[k];
			end
			rnd_valid_s3 <= div_valid_s2[DW];
			out_valid_q  <= rnd_valid_s3;
		end
	end

	// Divider chain: one dividend bit per stage, most significant bit first.
	always_ff @(posedge clk) begin
		if (advance) begin
			div_act_s2[0] <= head_act;
			div_neg_s2[0] <= head_diff[DW-1];
			div_mag_s2[0] <= head_mag;
			div_rem_s2[0] <= '0;
			for (int k = 0; k < DW; k++) begin
				div_act_s2[k+1] <= div_act_s2[k];
				div_neg_s2[k+1] <= div_neg_s2[k];
				div_mag_s2[k+1] <= div_mag_s2[k];
				div_rem_s2[k+1] <= rem_step(div_rem_s2[k], div_mag_s2[k][DW-1-k], spacing);
			end
			rnd_act_s3 <= div_act_s2[DW];
			rnd_neg_s3 <= div_neg_s2[DW];
			rnd_mag_s3 <= rnd_mag_next;
			goal_q     <= goal_next;
			action_q   <= rnd_act_s3;
		end
	end

	// Truncated multiple is the magnitude less the remainder; more than half a
	// pitch left over moves one pitch further from the start angle.
	assign fin_rem      = div_rem_s2[DW];
	assign round_up     = {fin_rem, 1'b0} > {1'b0, spacing};
	assign rnd_mag_next = MW'(div_mag_s2[DW]) - MW'(fin_rem)
	                    + (round_up ? MW'(spacing) : MW'(0));

	// Apply the sign around the start angle and saturate to the angle range.
	assign st_ext   = {{3{start_angle[ANGLE_WIDTH-1]}}, start_angle};
	assign mag_ext  = {1'b0, rnd_mag_s3};
	assign goal_sum = rnd_neg_s3 ? (st_ext - mag_ext) : (st_ext + mag_ext);
	assign sum_top  = goal_sum[SW-1:ANGLE_WIDTH-1];

	always_comb begin
		if ((sum_top == 4'b0000) || (sum_top == 4'b1111)) begin
			snap_goal = goal_sum[ANGLE_WIDTH-1:0];
		end else if (goal_sum[SW-1]) begin
			snap_goal = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
		end else begin
			snap_goal = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
		end
	end

	// Goal chosen by action; stopping reports a zero goal.
	always_comb begin
		case (rnd_act_s3)
			ACT_END:   goal_next = end_angle;
			ACT_START: goal_next = start_angle;
			ACT_SNAP:  goal_next = snap_goal;
			default:   goal_next = '0;
		endcase
	end

	assign goal.valid      = out_valid_q;
	assign goal.goal_angle = goal_q;
	assign goal.action     = action_q;

endmodule

/* sv/detent_goal_with_end_stops.sv */
// Top level of the detent goal block with end stops.
// Depends on dgs_pkg, dgs_if, dgs_front, dgs_queue and dgs_back.
//
//   Channel  Dir  Payload                        Transaction
//   angle    in   current_angle                  one measured angle per tick
//   goal     out  goal_angle, action             one goal per measured angle
//   cfg      in   index, data                    one register write
//
// One angle is accepted every cycle while the queue has room. Its goal passes
// through the capture register, the queue, the remainder divider stages (one
// dividend bit per stage), the rounding register and the output register.
// Reset clears the configuration registers, valid bits and queue pointers but
// not the data registers; there is no clearing pass. Register writes are taken
// in every cycle. A stalled goal holds the back pipeline; the front keeps taking
// angles until its queue of four entries is full.
module detent_goal_with_end_stops #(
	parameter int ANGLE_WIDTH = dgs_pkg::ANGLE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dgs_angle_if.sink  angle,
	dgs_cfg_if.sink    cfg,
	dgs_goal_if.source goal
);
	import dgs_pkg::*;

	localparam int ENTRY_W = ANGLE_WIDTH + 3;

	logic                          q_wr_valid;
	logic                          q_wr_ready;
	logic [ENTRY_W-1:0]            q_wr_data;
	logic                          q_rd_valid;
	logic                          q_rd_ready;
	logic [ENTRY_W-1:0]            q_rd_data;
	spacing_t                      spacing;
	logic signed [ANGLE_WIDTH-1:0] start_angle;
	logic signed [ANGLE_WIDTH-1:0] end_angle;

	dgs_front #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle       (angle),
		.cfg         (cfg),
		.wr_valid    (q_wr_valid),
		.wr_ready    (q_wr_ready),
		.wr_data     (q_wr_data),
		.spacing     (spacing),
		.start_angle (start_angle),
		.end_angle   (end_angle)
	);

	dgs_queue #(
		.DATA_W(ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	dgs_back #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid    (q_rd_valid),
		.rd_ready    (q_rd_ready),
		.rd_data     (q_rd_data),
		.spacing     (spacing),
		.start_angle (start_angle),
		.end_angle   (end_angle),
		.goal        (goal)
	);

`ifndef SYNTHESIS
	// A stop command always carries a zero goal.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		goal.valid && (goal.action == ACT_STOP) |-> (goal.goal_angle == '0))
		else $error("stop command with nonzero goal");

	// A stalled goal must freeze the back, so nothing leaves the queue.
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		goal.valid && !goal.ready |-> !(q_rd_valid && q_rd_ready))
		else $error("queue popped while the goal is stalled");

	// The front refuses an angle only when the queue has no room.
	a_front_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid && !angle.ready |-> !q_wr_ready)
		else $error("angle refused while the queue has room");

	// A pushed transaction that finds the queue full stays offered.
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr_valid && !q_wr_ready |=> q_wr_valid)
		else $error("front dropped a transaction waiting for the queue");
`endif

endmodule
